// File: sv/afc_pkg.sv
// ----------------------------------------------------------------------------
// afc_pkg
// shared types and constants of the box versus frustum culling block
// ----------------------------------------------------------------------------
package afc_pkg;

  localparam int unsigned PLANE_IDX_W = 3;
  localparam int unsigned Q_FRAC      = 16;
  localparam int unsigned OUT_TDATA_W = 8;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_TEST = 1'b1;

  typedef struct packed {
    logic                   load_en;
    logic                   start;
    logic                   issue;
    logic [PLANE_IDX_W-1:0] issue_idx;
    logic                   out_load;
  } afc_cmd_t;

  typedef struct packed {
    logic last_done;
  } afc_status_t;

endpackage

// File: sv/afc_ctrl.sv
// ----------------------------------------------------------------------------
// afc_ctrl
// sequencer: takes words, tracks loaded planes, issues one plane per cycle
// to the datapath and hands the verdict to the output register
// ----------------------------------------------------------------------------
module afc_ctrl
  import afc_pkg::*;
#(
  parameter int unsigned PLANE_COUNT = 6
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   mode_i,
  input  logic [PLANE_IDX_W-1:0] plane_index_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output afc_cmd_t               cmd_o,
  input  afc_status_t            status_i
);

  typedef enum logic [1:0] {
    IDLE,
    RUN,
    DRAIN,
    DONE
  } state_e;

  localparam logic [PLANE_IDX_W-1:0] LastIdx = PLANE_IDX_W'(PLANE_COUNT - 1);

  state_e                 state_q, state_d;
  logic [PLANE_IDX_W-1:0] cnt_q, cnt_d;
  logic [PLANE_COUNT-1:0] loaded_q, loaded_d;
  logic                   out_valid_q, out_valid_d;
  logic                   accept;
  logic                   index_ok;
  logic                   out_free;

  assign in_ready_o  = (state_q == IDLE);
  assign out_valid_o = out_valid_q;
  assign accept      = in_valid_i && in_ready_o;
  assign index_ok    = ({1'b0, plane_index_i} < (PLANE_IDX_W + 1)'(PLANE_COUNT));
  assign out_free    = !out_valid_q || out_ready_i;

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    loaded_d      = loaded_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    cmd_o         = '0;
    cmd_o.issue_idx = cnt_q;
    unique case (state_q)
      IDLE: begin
        if (accept) begin
          if (mode_i == MODE_LOAD) begin
            if (index_ok) begin
              cmd_o.load_en = 1'b1;
              loaded_d[plane_index_i[$clog2(PLANE_COUNT > 1 ? PLANE_COUNT : 2)-1:0]] = 1'b1;
            end
          end else if (&loaded_q) begin
            cmd_o.start = 1'b1;
            cnt_d       = '0;
            state_d     = RUN;
          end
        end
      end
      RUN: begin
        cmd_o.issue = 1'b1;
        if (cnt_q == LastIdx) begin
          state_d = DRAIN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      DRAIN: begin
        if (status_i.last_done) begin
          state_d = DONE;
        end
      end
      DONE: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = IDLE;
        end
      end
      default: state_d = IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= IDLE;
      cnt_q       <= '0;
      loaded_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      loaded_q    <= loaded_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: sv/afc_datapath.sv
// ----------------------------------------------------------------------------
// afc_datapath
// plane store, box registers and a two-stage plane test: three products of
// the farthest corner, then the exact sum with the offset and a sign check
// ----------------------------------------------------------------------------
module afc_datapath
  import afc_pkg::*;
#(
  parameter int unsigned PLANE_COUNT = 6,
  parameter int unsigned COORD_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  afc_cmd_t                      cmd_i,
  output afc_status_t                   status_o,
  input  logic [PLANE_IDX_W-1:0]        plane_index_i,
  input  logic signed [COORD_WIDTH-1:0] normal_i [3],
  input  logic signed [COORD_WIDTH-1:0] plane_offset_i,
  input  logic signed [COORD_WIDTH-1:0] box_min_i [3],
  input  logic signed [COORD_WIDTH-1:0] box_max_i [3],
  output logic                          visible_o,
  output logic [PLANE_IDX_W-1:0]        rejecting_plane_o
);

  localparam int unsigned IdxW  = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1;
  localparam int unsigned ProdW = 2 * COORD_WIDTH;
  localparam int unsigned SumW  = ProdW + 2;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(PLANE_COUNT - 1);

  logic signed [COORD_WIDTH-1:0] norm_q [PLANE_COUNT][3];
  logic signed [COORD_WIDTH-1:0] off_q  [PLANE_COUNT];
  logic signed [COORD_WIDTH-1:0] lo_q   [3];
  logic signed [COORD_WIDTH-1:0] hi_q   [3];
  logic                          ge_q   [3];

  logic [IdxW-1:0]               rd_idx;
  logic signed [COORD_WIDTH-1:0] csel [3];
  logic signed [ProdW-1:0]       prod_d [3];

  logic                          a_valid_q;
  logic [IdxW-1:0]               a_idx_q;
  logic signed [ProdW-1:0]       a_prod_q [3];
  logic signed [COORD_WIDTH-1:0] a_off_q;

  logic signed [SumW-1:0]        sum;
  logic                          b_valid_q;
  logic [IdxW-1:0]               b_idx_q;
  logic                          b_out_q;

  logic                          rej_found_q;
  logic [IdxW-1:0]               rej_idx_q;
  logic                          vis_q;
  logic [PLANE_IDX_W-1:0]        rej_plane_q;

  assign rd_idx = cmd_i.issue_idx[IdxW-1:0];

  // farthest corner along the normal, per axis
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (norm_q[rd_idx][i][COORD_WIDTH-1]) begin
        csel[i] = ge_q[i] ? lo_q[i] : hi_q[i];
      end else begin
        csel[i] = ge_q[i] ? hi_q[i] : lo_q[i];
      end
      prod_d[i] = ProdW'(norm_q[rd_idx][i]) * ProdW'(csel[i]);
    end
  end

  assign sum = SumW'(a_prod_q[0]) + SumW'(a_prod_q[1]) + SumW'(a_prod_q[2])
             + (SumW'(a_off_q) <<< Q_FRAC);

  assign status_o.last_done = b_valid_q && (b_idx_q == LastIdx);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_en) begin
      for (int i = 0; i < 3; i++) begin
        norm_q[plane_index_i[IdxW-1:0]][i] <= normal_i[i];
      end
      off_q[plane_index_i[IdxW-1:0]] <= plane_offset_i;
    end
    if (cmd_i.start) begin
      for (int i = 0; i < 3; i++) begin
        lo_q[i] <= box_min_i[i];
        hi_q[i] <= box_max_i[i];
        ge_q[i] <= (box_max_i[i] >= box_min_i[i]);
      end
    end
    a_idx_q <= rd_idx;
    a_off_q <= off_q[rd_idx];
    for (int i = 0; i < 3; i++) begin
      a_prod_q[i] <= prod_d[i];
    end
    b_idx_q <= a_idx_q;
    b_out_q <= sum[SumW-1];
    if (cmd_i.out_load) begin
      vis_q       <= !rej_found_q;
      rej_plane_q <= rej_found_q ? PLANE_IDX_W'(rej_idx_q) : PLANE_IDX_W'(PLANE_COUNT);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      rej_found_q <= 1'b0;
      rej_idx_q   <= '0;
    end else begin
      a_valid_q <= cmd_i.issue;
      b_valid_q <= a_valid_q;
      if (cmd_i.start) begin
        rej_found_q <= 1'b0;
      end else if (b_valid_q && b_out_q && !rej_found_q) begin
        rej_found_q <= 1'b1;
        rej_idx_q   <= b_idx_q;
      end
    end
  end

  assign visible_o         = vis_q;
  assign rejecting_plane_o = rej_plane_q;

endmodule

// File: sv/aabb_frustum_cull.sv
// ----------------------------------------------------------------------------
// aabb_frustum_cull
// axis-aligned box versus view frustum test in signed q16.16 fixed point
// ----------------------------------------------------------------------------
// A word with tuser = 0 loads one plane (normal and offset) into the plane
// store; it gives no result, and a plane index beyond the store is dropped.
// A word with tuser = 1 tests a box; it is dropped without a result until
// every plane has been loaded. A test checks one plane per cycle through a
// shared three-multiplier unit followed by an exact adder stage; the verdict
// then goes to the result register once the output side is free. The result
// reports visible, or the first plane that has all eight corners outside.
// ----------------------------------------------------------------------------
module aabb_frustum_cull
  import afc_pkg::*;
#(
  parameter int unsigned PLANE_COUNT = 6,
  parameter int unsigned COORD_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // plane_index, normal_x, normal_y, normal_z, plane_offset,
  // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z
  input  logic [((PLANE_IDX_W + 10 * COORD_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
  // mode
  input  logic [0:0]             s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // visible, rejecting_plane
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  localparam int unsigned Cw = COORD_WIDTH;

  afc_cmd_t               cmd;
  afc_status_t            status;
  logic signed [Cw-1:0]   normal [3];
  logic signed [Cw-1:0]   box_min [3];
  logic signed [Cw-1:0]   box_max [3];
  logic signed [Cw-1:0]   plane_offset;
  logic                   visible;
  logic [PLANE_IDX_W-1:0] rejecting_plane;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      normal[i]  = s_axis_tdata[PLANE_IDX_W + i * Cw +: Cw];
      box_min[i] = s_axis_tdata[PLANE_IDX_W + (4 + i) * Cw +: Cw];
      box_max[i] = s_axis_tdata[PLANE_IDX_W + (7 + i) * Cw +: Cw];
    end
  end
  assign plane_offset = s_axis_tdata[PLANE_IDX_W + 3 * Cw +: Cw];

  afc_ctrl #(
    .PLANE_COUNT(PLANE_COUNT)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .mode_i       (s_axis_tuser[0]),
    .plane_index_i(s_axis_tdata[PLANE_IDX_W-1:0]),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .cmd_o        (cmd),
    .status_i     (status)
  );

  afc_datapath #(
    .PLANE_COUNT(PLANE_COUNT),
    .COORD_WIDTH(COORD_WIDTH)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .plane_index_i    (s_axis_tdata[PLANE_IDX_W-1:0]),
    .normal_i         (normal),
    .plane_offset_i   (plane_offset),
    .box_min_i        (box_min),
    .box_max_i        (box_max),
    .visible_o        (visible),
    .rejecting_plane_o(rejecting_plane)
  );

  assign m_axis_tdata = {{(OUT_TDATA_W - PLANE_IDX_W - 1){1'b0}}, rejecting_plane, visible};

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the box versus six-plane frustum culling block
// ----------------------------------------------------------------------------
// Plane loads and box tests are sent over the input stream in bursts with
// random gaps, while the output side stalls on a changing ready pattern. A
// predictor keeps its own plane store and loaded mask, works out the exact
// sign of n.c + d for all eight corners of every box, and queues the expected
// verdict; each output word is checked against the oldest one. Directed words
// cover tests before the store is full, plane indexes beyond the store,
// corners exactly on a plane, inverted boxes and the extremes of q16.16.
// Random phases use an axis-aligned frustum, fully random planes and noise.
// ----------------------------------------------------------------------------
module tb_top
  import afc_pkg::*;
();

  localparam int unsigned N_PLANES    = 6;
  localparam int unsigned COORD_W     = 32;
  localparam int unsigned IN_TDATA_W  = ((PLANE_IDX_W + 10 * COORD_W + 7) / 8) * 8;
  localparam int unsigned CYCLE_LIMIT = 500000;

  localparam logic [COORD_W-1:0] Q_ONE     = 32'h0001_0000;
  localparam logic [COORD_W-1:0] Q_NEG_ONE = 32'hffff_0000;
  localparam logic [COORD_W-1:0] Q_MAX     = 32'h7fff_ffff;
  localparam logic [COORD_W-1:0] Q_MIN     = 32'h8000_0000;

  typedef struct packed {
    logic                         mode;
    logic [PLANE_IDX_W-1:0]       idx;
    logic [3:0][COORD_W-1:0]      plane;  // nx, ny, nz, offset from index 0 up
    logic [5:0][COORD_W-1:0]      box;    // min x y z, max x y z from index 0 up
  } cull_item_t;

  typedef struct packed {
    logic                   visible;
    logic [PLANE_IDX_W-1:0] plane;
  } verdict_t;

  logic                   clk_i = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // plane_index, normal_x, normal_y, normal_z, plane_offset,
  // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  // mode
  logic [0:0]             s_axis_tuser = MODE_LOAD;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // visible, rejecting_plane
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  logic [3:0][COORD_W-1:0] plane_mem [N_PLANES];
  logic [N_PLANES-1:0]     plane_loaded = '0;
  verdict_t                expected_verdicts [$];

  int          errors       = 0;
  int          burst_left   = 0;
  int          n_loads      = 0;
  int          n_dropped    = 0;
  int          n_visible    = 0;
  int          n_culled     = 0;
  int unsigned cycle_count  = 0;
  logic [15:0] ready_pat    = 16'hffff;
  logic [6:0]  stall_step   = '0;

  aabb_frustum_cull #(
    .PLANE_COUNT(N_PLANES),
    .COORD_WIDTH(COORD_W)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d verdicts outstanding", $time,
               expected_verdicts.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // output side ready pattern, reshuffled each time stall_step wraps to zero
  always @(posedge clk_i) begin
    if (stall_step == 0) begin
      case ($urandom_range(0, 3))
        0:       ready_pat = 16'hffff;
        1:       ready_pat = 16'($urandom);
        2:       ready_pat = 16'($urandom & $urandom);
        default: ready_pat = ~(16'h1 << $urandom_range(0, 15));
      endcase
      ready_pat = ready_pat | 16'h0001;
    end
    m_axis_tready <= ready_pat[stall_step[3:0]];
    stall_step = stall_step + 7'd1;
  end

  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_n && m_axis_tvalid && m_axis_tready) begin
      if (expected_verdicts.size() == 0) begin
        errors++;
        if (errors < 50)
          $display("%0t: unexpected word, expected none, got 0x%02h", $time, m_axis_tdata);
      end else begin
        want = expected_verdicts.pop_front();
        if (m_axis_tdata[0] !== want.visible) begin
          errors++;
          if (errors < 50)
            $display("%0t: visible mismatch, expected %0d, got %0d", $time,
                     want.visible, m_axis_tdata[0]);
        end
        if (m_axis_tdata[PLANE_IDX_W:1] !== want.plane) begin
          errors++;
          if (errors < 50)
            $display("%0t: rejecting_plane mismatch, expected %0d, got %0d", $time,
                     want.plane, m_axis_tdata[PLANE_IDX_W:1]);
        end
      end
    end
  end

  function automatic logic [COORD_W-1:0] fix16(input int v);
    return 32'(v * 65536);
  endfunction

  function automatic logic [COORD_W-1:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return Q_MIN;
      1:       return Q_MAX;
      2:       return '0;
      3:       return '1;
      4, 5:    return 32'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
      default: return $urandom;
    endcase
  endfunction

  // exact corner test: all eight corners strictly below zero
  function automatic logic all_corners_outside(input logic [3:0][COORD_W-1:0] pl,
                                               input logic [5:0][COORD_W-1:0] bx);
    logic signed [127:0] acc;
    logic signed [127:0] n;
    logic signed [127:0] c;
    for (int ci = 0; ci < 8; ci++) begin
      acc = 128'($signed(pl[3]));
      acc = acc <<< Q_FRAC;
      for (int a = 0; a < 3; a++) begin
        n = 128'($signed(pl[a]));
        c = 128'($signed(((ci >> (2 - a)) & 1) ? bx[3 + a] : bx[a]));
        acc = acc + n * c;
      end
      if (!acc[127]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic predict_verdict(input cull_item_t it, output verdict_t v);
    v = '0;
    if (it.mode == MODE_LOAD) begin
      if (it.idx < N_PLANES) begin
        plane_mem[it.idx] = it.plane;
        plane_loaded[it.idx] = 1'b1;
        n_loads++;
      end else begin
        n_dropped++;
      end
      return 1'b0;
    end
    if (plane_loaded != '1) begin
      n_dropped++;
      return 1'b0;
    end
    for (int k = 0; k < N_PLANES; k++) begin
      if (all_corners_outside(plane_mem[k], it.box)) begin
        v.visible = 1'b0;
        v.plane = PLANE_IDX_W'(k);
        n_culled++;
        return 1'b1;
      end
    end
    v.visible = 1'b1;
    v.plane = PLANE_IDX_W'(N_PLANES);
    n_visible++;
    return 1'b1;
  endfunction

  task automatic send_item(input cull_item_t it);
    verdict_t v;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) == 0) burst_left = $urandom_range(30, 80);
      else burst_left = $urandom_range(1, 24);
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.mode;
    s_axis_tdata  <= IN_TDATA_W'({it.box, it.plane, it.idx});
    do @(posedge clk_i); while (!s_axis_tready);
    burst_left--;
    if (predict_verdict(it, v)) expected_verdicts.insert(expected_verdicts.size(), v);
  endtask

  task automatic send_plane(input logic [PLANE_IDX_W-1:0] idx,
                            input logic [COORD_W-1:0] nx, ny, nz, d);
    cull_item_t it;
    it.mode  = MODE_LOAD;
    it.idx   = idx;
    it.plane = {d, nz, ny, nx};
    for (int i = 0; i < 6; i++) it.box[i] = $urandom;
    send_item(it);
  endtask

  task automatic send_box(input logic [COORD_W-1:0] x0, y0, z0, x1, y1, z1);
    cull_item_t it;
    it.mode = MODE_TEST;
    it.idx  = PLANE_IDX_W'($urandom_range(0, 7));
    for (int i = 0; i < 4; i++) it.plane[i] = $urandom;
    it.box  = {z1, y1, x1, z0, y0, x0};
    send_item(it);
  endtask

  // cube frustum |x|,|y|,|z| <= r: left right bottom top near far
  task automatic send_cube_plane(input int k, input logic [COORD_W-1:0] r);
    case (k)
      0:       send_plane(PLANE_IDX_W'(k), Q_ONE, '0, '0, r);
      1:       send_plane(PLANE_IDX_W'(k), Q_NEG_ONE, '0, '0, r);
      2:       send_plane(PLANE_IDX_W'(k), '0, Q_ONE, '0, r);
      3:       send_plane(PLANE_IDX_W'(k), '0, Q_NEG_ONE, '0, r);
      4:       send_plane(PLANE_IDX_W'(k), '0, '0, Q_ONE, r);
      default: send_plane(PLANE_IDX_W'(k), '0, '0, Q_NEG_ONE, r);
    endcase
  endtask

  task automatic wait_for_verdicts();
    s_axis_tvalid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  // tests are dropped until all six planes exist, indexes past the store too
  task automatic test_plane_loading();
    send_box(fix16(-10), fix16(-10), fix16(-10), fix16(10), fix16(10), fix16(10));
    send_plane(3'd6, $urandom, $urandom, $urandom, $urandom);
    send_plane(3'd7, $urandom, $urandom, $urandom, $urandom);
    for (int k = 0; k < 5; k++) send_cube_plane(k, fix16(100));
    send_box(fix16(-10), fix16(-10), fix16(-10), fix16(10), fix16(10), fix16(10));
    send_cube_plane(5, fix16(100));
  endtask

  task automatic test_directed_culls();
    send_box(fix16(-10), fix16(-10), fix16(-10), fix16(10), fix16(10), fix16(10));
    send_box(fix16(-300), fix16(-10), fix16(-10), fix16(-200), fix16(10), fix16(10));
    send_box(fix16(200), fix16(-10), fix16(-10), fix16(300), fix16(10), fix16(10));
    send_box(fix16(-10), fix16(-300), fix16(-10), fix16(10), fix16(-200), fix16(10));
    send_box(fix16(-10), fix16(200), fix16(-10), fix16(10), fix16(300), fix16(10));
    send_box(fix16(-10), fix16(-10), fix16(-300), fix16(10), fix16(10), fix16(-200));
    send_box(fix16(-10), fix16(-10), fix16(200), fix16(10), fix16(10), fix16(300));
    // outside two planes, the lower index wins
    send_box(fix16(-300), fix16(200), fix16(-10), fix16(-200), fix16(300), fix16(10));
    // corner exactly on the left plane counts as inside
    send_box(fix16(-300), fix16(-10), fix16(-10), fix16(-100), fix16(10), fix16(10));
    send_box(fix16(-300), fix16(-10), fix16(-10), fix16(-100) - 1, fix16(10), fix16(10));
    // min above max
    send_box(fix16(10), fix16(10), fix16(10), fix16(-10), fix16(-10), fix16(-10));
    send_box(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX);
    send_plane(3'd0, Q_MAX, Q_MAX, Q_MAX, Q_MIN);
    send_plane(3'd1, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
    send_box(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
    send_box(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
    send_box(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX);
  endtask

  task automatic test_random_cube(input int count);
    int r;
    int c;
    int h;
    int t;
    int lo [3];
    int hi [3];
    for (int i = 0; i < count; i++) begin
      if (i % 60 == 0) begin
        r = int'($urandom_range(1, 2000)) * 65536;
        for (int k = 0; k < N_PLANES; k++) send_cube_plane(k, r);
      end
      for (int a = 0; a < 3; a++) begin
        c = int'($urandom_range(0, 4 * r)) - 2 * r;
        h = int'($urandom_range(0, r));
        lo[a] = c - h;
        hi[a] = c + h;
        if ($urandom_range(0, 9) == 0) begin
          t = lo[a];
          lo[a] = hi[a];
          hi[a] = t;
        end
      end
      if ($urandom_range(0, 7) == 0) begin
        t = $urandom_range(0, 2);
        hi[t] = -r;
        lo[t] = -r - int'($urandom_range(0, r));
      end
      send_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
    end
  endtask

  task automatic test_random_planes(input int count);
    logic [COORD_W-1:0] c;
    logic [COORD_W-1:0] h;
    logic [COORD_W-1:0] lo [3];
    logic [COORD_W-1:0] hi [3];
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0)
        for (int k = 0; k < N_PLANES; k++)
          send_plane(PLANE_IDX_W'(k), rand_word(), rand_word(), rand_word(), rand_word());
      if ($urandom_range(0, 9) == 0) begin
        send_plane(PLANE_IDX_W'($urandom_range(0, 7)), rand_word(), rand_word(),
                   rand_word(), rand_word());
      end else begin
        for (int a = 0; a < 3; a++) begin
          c = rand_word();
          h = $urandom >> $urandom_range(1, 31);
          lo[a] = c - h;
          hi[a] = c + h;
          if ($urandom_range(0, 9) == 0) lo[a] = c + h;
        end
        send_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
      end
    end
  endtask

  task automatic test_noise(input int count);
    cull_item_t it;
    for (int i = 0; i < count; i++) begin
      it.mode = $urandom_range(0, 1) ? MODE_TEST : MODE_LOAD;
      it.idx  = PLANE_IDX_W'($urandom_range(0, 7));
      for (int k = 0; k < 4; k++) it.plane[k] = rand_word();
      for (int k = 0; k < 6; k++) it.box[k] = rand_word();
      send_item(it);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);
    test_plane_loading();
    wait_for_verdicts();
    test_directed_culls();
    wait_for_verdicts();
    test_random_cube(450);
    wait_for_verdicts();
    test_random_planes(520);
    wait_for_verdicts();
    test_noise(300);
    wait_for_verdicts();
    repeat (20) @(posedge clk_i);
    $display("covered %0d plane loads and %0d dropped words", n_loads, n_dropped);
    $display("checked %0d box tests: %0d visible, %0d culled", n_visible + n_culled,
             n_visible, n_culled);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: aabb_frustum_cull.f
sv/afc_pkg.sv
sv/afc_ctrl.sv
sv/afc_datapath.sv
sv/aabb_frustum_cull.sv
tb/sv/tb_top.sv
